// ===== src/i2cm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    // Command codes carried in the func field
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_HOLD       = 2'd0;
    localparam logic [1:0] CFG_BIT_PHASE  = 2'd1;
    localparam logic [1:0] CFG_SETTLE     = 2'd2;
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd3;

    localparam int CFG_DATA_W = 10;

    // Reset values of the configuration registers
    localparam logic [7:0] HOLD_RST       = 8'd4;
    localparam logic [7:0] BIT_PHASE_RST  = 8'd2;
    localparam logic [7:0] SETTLE_RST     = 8'd1;
    localparam logic [9:0] POLL_LIMIT_RST = 10'd250;

    // Bits in one byte transfer
    localparam logic [3:0] BYTE_BITS = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ST_A     = 4'd1,
        PH_ST_B     = 4'd2,
        PH_SP_A     = 4'd3,
        PH_SP_B     = 4'd4,
        PH_WR_SETUP = 4'd5,
        PH_WR_HIGH  = 4'd6,
        PH_WR_TAIL  = 4'd7,
        PH_ACK_REL  = 4'd8,
        PH_ACK_SCL  = 4'd9,
        PH_ACK_POLL = 4'd10,
        PH_RD_LOW   = 4'd11,
        PH_RD_HIGH  = 4'd12,
        PH_RK_LOW   = 4'd13,
        PH_RK_HIGH  = 4'd14
    } phase_t;

    typedef struct packed {
        logic [7:0] hold;
        logic [7:0] bit_phase;
        logic [7:0] settle;
        logic [9:0] poll_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       ack_failed;
        logic       done;
    } res_t;

    typedef struct packed {
        logic       over;
        logic [7:0] tick;
    } tick_step_t;

    // Advance the phase tick counter; a length of zero counts as one
    function automatic tick_step_t phase_over(input logic [7:0] tick, input logic [7:0] len);
        logic [8:0] n;
        logic [7:0] lim;
        tick_step_t r;
        n   = {1'b0, tick} + 9'd1;
        lim = (len == 8'd0) ? 8'd1 : len;
        if (n >= {1'b0, lim}) begin
            r.over = 1'b1;
            r.tick = 8'd0;
        end else begin
            r.over = 1'b0;
            r.tick = n[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/i2cm_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cm_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output i2cm_pkg::cfg_t                     cfg
);

    i2cm_pkg::cfg_t cfg_reg;

    // Write one register per enabled beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold       <= i2cm_pkg::HOLD_RST;
            cfg_reg.bit_phase  <= i2cm_pkg::BIT_PHASE_RST;
            cfg_reg.settle     <= i2cm_pkg::SETTLE_RST;
            cfg_reg.poll_limit <= i2cm_pkg::POLL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                i2cm_pkg::CFG_HOLD:       cfg_reg.hold       <= cfg_wdata[7:0];
                i2cm_pkg::CFG_BIT_PHASE:  cfg_reg.bit_phase  <= cfg_wdata[7:0];
                i2cm_pkg::CFG_SETTLE:     cfg_reg.settle     <= cfg_wdata[7:0];
                i2cm_pkg::CFG_POLL_LIMIT: cfg_reg.poll_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/i2cm_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cm_fsm (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire i2cm_pkg::item_t  item,
    input  wire i2cm_pkg::cfg_t   cfg,
    output i2cm_pkg::res_t        res
);

    i2cm_pkg::phase_t phase_reg, phase_next;
    logic [2:0] command_reg, command_next;
    logic [7:0] tick_reg, tick_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [9:0] poll_count_reg, poll_count_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       sda_oe_reg, sda_oe_next;
    logic [7:0] rx_hold_reg, rx_hold_next;
    logic       rx_valid, ack_failed, done;
    logic [3:0] bit_count_inc;

    i2cm_pkg::tick_step_t ts_hold, ts_bit, ts_settle;

    // Tick counter outcomes for each phase length
    always_comb begin
        ts_hold   = i2cm_pkg::phase_over(tick_reg, cfg.hold);
        ts_bit    = i2cm_pkg::phase_over(tick_reg, cfg.bit_phase);
        ts_settle = i2cm_pkg::phase_over(tick_reg, cfg.settle);
    end

    assign bit_count_inc = bit_count_reg + 4'd1;

    // Next state and bus levels for one item
    always_comb begin
        phase_next      = phase_reg;
        command_next    = command_reg;
        tick_next       = tick_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        poll_count_next = poll_count_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_oe_next     = sda_oe_reg;
        rx_hold_next    = rx_hold_reg;
        rx_valid        = 1'b0;
        ack_failed      = 1'b0;
        done            = 1'b0;

        unique case (phase_reg)
            i2cm_pkg::PH_IDLE: begin
                tick_next = 8'd0;
                priority case (item.func)
                    i2cm_pkg::FUNC_START: begin
                        sda_oe_next  = 1'b1;
                        sda_next     = 1'b1;
                        scl_next     = 1'b1;
                        command_next = i2cm_pkg::FUNC_START;
                        phase_next   = i2cm_pkg::PH_ST_A;
                    end
                    i2cm_pkg::FUNC_STOP: begin
                        command_next = i2cm_pkg::FUNC_STOP;
                        scl_next     = 1'b0;
                        sda_next     = 1'b0;
                        sda_oe_next  = 1'b1;
                        phase_next   = i2cm_pkg::PH_SP_A;
                    end
                    i2cm_pkg::FUNC_WRITE: begin
                        bit_count_next = 4'd0;
                        command_next   = i2cm_pkg::FUNC_WRITE;
                        sda_next       = item.tx_byte[7];
                        shift_next     = {item.tx_byte[6:0], 1'b0};
                        scl_next       = 1'b0;
                        sda_oe_next    = 1'b1;
                        phase_next     = i2cm_pkg::PH_WR_SETUP;
                    end
                    i2cm_pkg::FUNC_READ: begin
                        sda_oe_next     = 1'b0;
                        sda_next        = 1'b1;
                        scl_next        = 1'b0;
                        bit_count_next  = 4'd0;
                        shift_next      = 8'd0;
                        ack_choice_next = item.send_ack;
                        command_next    = i2cm_pkg::FUNC_READ;
                        phase_next      = i2cm_pkg::PH_RD_LOW;
                    end
                    default: ;
                endcase
            end
            i2cm_pkg::PH_ST_A: begin
                tick_next = ts_hold.tick;
                if (ts_hold.over) begin
                    sda_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_ST_B;
                end
            end
            i2cm_pkg::PH_ST_B: begin
                tick_next = ts_hold.tick;
                if (ts_hold.over) begin
                    scl_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end
            end
            i2cm_pkg::PH_SP_A: begin
                tick_next = ts_hold.tick;
                if (ts_hold.over) begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_SP_B;
                end
            end
            i2cm_pkg::PH_SP_B: begin
                tick_next = ts_hold.tick;
                if (ts_hold.over) begin
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                    ack_failed = (command_reg == i2cm_pkg::FUNC_WRITE);
                end
            end
            i2cm_pkg::PH_WR_SETUP: begin
                tick_next = ts_bit.tick;
                if (ts_bit.over) begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_WR_HIGH;
                end
            end
            i2cm_pkg::PH_WR_HIGH: begin
                tick_next = ts_bit.tick;
                if (ts_bit.over) begin
                    scl_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_WR_TAIL;
                end
            end
            i2cm_pkg::PH_WR_TAIL: begin
                tick_next = ts_bit.tick;
                if (ts_bit.over) begin
                    bit_count_next = bit_count_inc;
                    if (bit_count_inc < i2cm_pkg::BYTE_BITS) begin
                        sda_next    = shift_reg[7];
                        shift_next  = {shift_reg[6:0], 1'b0};
                        scl_next    = 1'b0;
                        sda_oe_next = 1'b1;
                        phase_next  = i2cm_pkg::PH_WR_SETUP;
                    end else begin
                        sda_oe_next = 1'b0;
                        sda_next    = 1'b1;
                        phase_next  = i2cm_pkg::PH_ACK_REL;
                    end
                end
            end
            i2cm_pkg::PH_ACK_REL: begin
                tick_next = ts_settle.tick;
                if (ts_settle.over) begin
                    scl_next        = 1'b1;
                    poll_count_next = 10'd0;
                    phase_next      = i2cm_pkg::PH_ACK_SCL;
                end
            end
            i2cm_pkg::PH_ACK_SCL: begin
                tick_next = ts_settle.tick;
                if (ts_settle.over) begin
                    phase_next = i2cm_pkg::PH_ACK_POLL;
                end
            end
            i2cm_pkg::PH_ACK_POLL: begin
                // Poll once per tick; give up with a stop past the limit
                if (!item.sda_in) begin
                    scl_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_IDLE;
                    done       = 1'b1;
                end else if (poll_count_reg >= cfg.poll_limit) begin
                    scl_next    = 1'b0;
                    sda_next    = 1'b0;
                    sda_oe_next = 1'b1;
                    tick_next   = 8'd0;
                    phase_next  = i2cm_pkg::PH_SP_A;
                end else begin
                    poll_count_next = poll_count_reg + 10'd1;
                end
            end
            i2cm_pkg::PH_RD_LOW: begin
                tick_next = ts_bit.tick;
                if (ts_bit.over) begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_RD_HIGH;
                end
            end
            i2cm_pkg::PH_RD_HIGH: begin
                tick_next = ts_settle.tick;
                if (ts_settle.over) begin
                    shift_next     = {shift_reg[6:0], item.sda_in};
                    bit_count_next = bit_count_inc;
                    scl_next       = 1'b0;
                    if (bit_count_inc < i2cm_pkg::BYTE_BITS) begin
                        phase_next = i2cm_pkg::PH_RD_LOW;
                    end else begin
                        sda_oe_next = 1'b1;
                        sda_next    = ~ack_choice_reg;
                        phase_next  = i2cm_pkg::PH_RK_LOW;
                    end
                end
            end
            i2cm_pkg::PH_RK_LOW: begin
                tick_next = ts_bit.tick;
                if (ts_bit.over) begin
                    scl_next   = 1'b1;
                    phase_next = i2cm_pkg::PH_RK_HIGH;
                end
            end
            i2cm_pkg::PH_RK_HIGH: begin
                tick_next = ts_bit.tick;
                if (ts_bit.over) begin
                    scl_next     = 1'b0;
                    rx_hold_next = shift_reg;
                    rx_valid     = 1'b1;
                    phase_next   = i2cm_pkg::PH_IDLE;
                    done         = 1'b1;
                end
            end
            default: begin
                phase_next = i2cm_pkg::PH_IDLE;
            end
        endcase
    end

    // Hold state between beats; advance on each item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= i2cm_pkg::PH_IDLE;
            command_reg    <= 3'd0;
            tick_reg       <= 8'd0;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            poll_count_reg <= 10'd0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            sda_oe_reg     <= 1'b1;
            rx_hold_reg    <= 8'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            command_reg    <= command_next;
            tick_reg       <= tick_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            poll_count_reg <= poll_count_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            sda_oe_reg     <= sda_oe_next;
            rx_hold_reg    <= rx_hold_next;
        end
    end

    // Result of this item
    always_comb begin
        res.scl_level  = scl_next;
        res.sda_level  = sda_oe_next ? sda_next : 1'b1;
        res.sda_drive  = sda_oe_next;
        res.busy       = (phase_next != i2cm_pkg::PH_IDLE);
        res.rx_byte    = rx_hold_next;
        res.rx_valid   = rx_valid;
        res.ack_failed = ack_failed;
        res.done       = done;
    end

    a_rx_ends_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.rx_valid |-> res.done && !res.busy && command_reg == i2cm_pkg::FUNC_READ)
        else $error("rx_valid without finishing a read");

    a_fail_is_write: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.ack_failed |-> res.done && command_reg == i2cm_pkg::FUNC_WRITE)
        else $error("ack failure outside a write");

    a_tick_keeps_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == i2cm_pkg::PH_IDLE && item.func == i2cm_pkg::FUNC_TICK
        |=> phase_reg == i2cm_pkg::PH_IDLE)
        else $error("tick left the idle phase");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg) && $stable(tick_reg) && $stable(scl_reg))
        else $error("state moved without an item");

endmodule

`default_nettype wire

// ===== src/i2c_bit_level_master_top.sv =====
// Flow: an accepted item sits in the input register; when the result register
// is empty or being read, the sequencer steps on the item and the result
// register loads, and the result is then valid on the m_ ports.
// Throughput: one item per cycle unless m_ready stalls; the state update for an
// item is a single pass of the phase sequencer between input and result registers.
// Reset: synchronous, active low; SCL and SDA driven high, phase idle, both
// pipeline registers empty, registers return to their default timing values.
`timescale 1ns / 1ps
`default_nettype none

module i2c_bit_level_master_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [1:0]                      cfg_addr,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire logic [2:0]                      s_func,
    input  wire logic [7:0]                      s_tx_byte,
    input  wire logic                            s_send_ack,
    input  wire logic                            s_sda_in,
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      logic                            m_scl_level,
    output      logic                            m_sda_level,
    output      logic                            m_sda_drive,
    output      logic                            m_busy_res,
    output      logic [7:0]                      m_rx_byte,
    output      logic                            m_rx_valid,
    output      logic                            m_ack_failed,
    output      logic                            m_done_res
);

    i2cm_pkg::cfg_t  cfg;
    i2cm_pkg::item_t in_item_reg;
    i2cm_pkg::res_t  res, out_res_reg;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic            advance;

    i2cm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Move an item from the input register to the result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    i2cm_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.func     <= s_func;
            in_item_reg.tx_byte  <= s_tx_byte;
            in_item_reg.send_ack <= s_send_ack;
            in_item_reg.sda_in   <= s_sda_in;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_scl_level  = out_res_reg.scl_level;
    assign m_sda_level  = out_res_reg.sda_level;
    assign m_sda_drive  = out_res_reg.sda_drive;
    assign m_busy_res   = out_res_reg.busy;
    assign m_rx_byte    = out_res_reg.rx_byte;
    assign m_rx_valid   = out_res_reg.rx_valid;
    assign m_ack_failed = out_res_reg.ack_failed;
    assign m_done_res   = out_res_reg.done;

    a_released_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sda_drive |-> m_sda_level)
        else $error("released SDA reported low");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done while still busy");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result beat lost");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import i2cm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SHOWN_ERRORS = 100;

    // Clock, reset and DUT ports
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_addr = CFG_HOLD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_func = FUNC_TICK;
    logic [7:0]            s_tx_byte = 8'h00;
    logic                  s_send_ack = 1'b0;
    logic                  s_sda_in = 1'b1;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_scl_level;
    logic                  m_sda_level;
    logic                  m_sda_drive;
    logic                  m_busy_res;
    logic [7:0]            m_rx_byte;
    logic                  m_rx_valid;
    logic                  m_ack_failed;
    logic                  m_done_res;

    // Bus master state mirrored by the predictor
    cfg_t       timing;
    phase_t     ph;
    logic [2:0] cmd;
    logic [7:0] tcnt;
    logic [3:0] nbits;
    logic [7:0] sh;
    logic [9:0] polls;
    logic       ack_sel;
    logic       scl, sda, oe;
    logic [7:0] rx_last;

    // Expected bus levels and flags, one entry per accepted beat
    res_t bus_results_due[$];
    res_t due;

    bit stall_en = 1'b1;
    int n_errors = 0;
    int n_items = 0;
    int n_checked = 0;
    int n_bytes_read = 0;
    int n_ack_fail = 0;
    int n_settings = 0;
    int quiet_cycles = 0;

    i2c_bit_level_master_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_tx_byte   (s_tx_byte),
        .s_send_ack  (s_send_ack),
        .s_sda_in    (s_sda_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_level (m_scl_level),
        .m_sda_level (m_sda_level),
        .m_sda_drive (m_sda_drive),
        .m_busy_res  (m_busy_res),
        .m_rx_byte   (m_rx_byte),
        .m_rx_valid  (m_rx_valid),
        .m_ack_failed(m_ack_failed),
        .m_done_res  (m_done_res)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Count one tick of the current phase; true when the phase is over
    function automatic bit phase_ends(input logic [7:0] len);
        if (len <= 8'd1 || tcnt >= len - 8'd1) begin
            tcnt = 8'd0;
            return 1'b1;
        end
        tcnt = tcnt + 8'd1;
        return 1'b0;
    endfunction

    // Put the next MSB on SDA with SCL low
    function automatic void shift_out_bit();
        sda = sh[7];
        sh = {sh[6:0], 1'b0};
        scl = 1'b0;
        oe = 1'b1;
        ph = PH_WR_SETUP;
    endfunction

    function automatic void begin_stop();
        scl = 1'b0;
        sda = 1'b0;
        oe = 1'b1;
        tcnt = 8'd0;
        ph = PH_SP_A;
    endfunction

    // Advance the bus master by one beat and return the levels it drives
    function automatic res_t bus_step(input item_t it);
        res_t r;
        logic rxv, fail, fin;
        rxv = 1'b0;
        fail = 1'b0;
        fin = 1'b0;
        if (ph == PH_IDLE) begin
            tcnt = 8'd0;
            case (it.func)
                FUNC_START: begin
                    oe = 1'b1;
                    sda = 1'b1;
                    scl = 1'b1;
                    cmd = FUNC_START;
                    ph = PH_ST_A;
                end
                FUNC_STOP: begin
                    cmd = FUNC_STOP;
                    begin_stop();
                end
                FUNC_WRITE: begin
                    sh = it.tx_byte;
                    nbits = 4'd0;
                    cmd = FUNC_WRITE;
                    shift_out_bit();
                end
                FUNC_READ: begin
                    oe = 1'b0;
                    sda = 1'b1;
                    scl = 1'b0;
                    nbits = 4'd0;
                    sh = 8'h00;
                    ack_sel = it.send_ack;
                    cmd = FUNC_READ;
                    ph = PH_RD_LOW;
                end
                default: ;
            endcase
        end else begin
            case (ph)
                PH_ST_A: if (phase_ends(timing.hold)) begin
                    sda = 1'b0;
                    ph = PH_ST_B;
                end
                PH_ST_B: if (phase_ends(timing.hold)) begin
                    scl = 1'b0;
                    ph = PH_IDLE;
                    fin = 1'b1;
                end
                PH_SP_A: if (phase_ends(timing.hold)) begin
                    scl = 1'b1;
                    sda = 1'b1;
                    ph = PH_SP_B;
                end
                PH_SP_B: if (phase_ends(timing.hold)) begin
                    ph = PH_IDLE;
                    fin = 1'b1;
                    fail = (cmd == FUNC_WRITE);
                end
                PH_WR_SETUP: if (phase_ends(timing.bit_phase)) begin
                    scl = 1'b1;
                    ph = PH_WR_HIGH;
                end
                PH_WR_HIGH: if (phase_ends(timing.bit_phase)) begin
                    scl = 1'b0;
                    ph = PH_WR_TAIL;
                end
                PH_WR_TAIL: if (phase_ends(timing.bit_phase)) begin
                    nbits = nbits + 4'd1;
                    if (nbits < BYTE_BITS) begin
                        shift_out_bit();
                    end else begin
                        oe = 1'b0;
                        sda = 1'b1;
                        ph = PH_ACK_REL;
                    end
                end
                PH_ACK_REL: if (phase_ends(timing.settle)) begin
                    scl = 1'b1;
                    polls = 10'd0;
                    ph = PH_ACK_SCL;
                end
                PH_ACK_SCL: if (phase_ends(timing.settle)) begin
                    ph = PH_ACK_POLL;
                end
                PH_ACK_POLL: begin
                    if (!it.sda_in) begin
                        scl = 1'b0;
                        ph = PH_IDLE;
                        fin = 1'b1;
                    end else if (polls >= timing.poll_limit) begin
                        begin_stop();
                    end else begin
                        polls = polls + 10'd1;
                    end
                end
                PH_RD_LOW: if (phase_ends(timing.bit_phase)) begin
                    scl = 1'b1;
                    ph = PH_RD_HIGH;
                end
                PH_RD_HIGH: if (phase_ends(timing.settle)) begin
                    sh = {sh[6:0], it.sda_in};
                    nbits = nbits + 4'd1;
                    scl = 1'b0;
                    if (nbits < BYTE_BITS) begin
                        ph = PH_RD_LOW;
                    end else begin
                        oe = 1'b1;
                        sda = !ack_sel;
                        ph = PH_RK_LOW;
                    end
                end
                PH_RK_LOW: if (phase_ends(timing.bit_phase)) begin
                    scl = 1'b1;
                    ph = PH_RK_HIGH;
                end
                PH_RK_HIGH: if (phase_ends(timing.bit_phase)) begin
                    scl = 1'b0;
                    rx_last = sh;
                    rxv = 1'b1;
                    ph = PH_IDLE;
                    fin = 1'b1;
                end
                default: ph = PH_IDLE;
            endcase
        end
        r.scl_level = scl;
        r.sda_level = oe ? sda : 1'b1;
        r.sda_drive = oe;
        r.busy = (ph != PH_IDLE);
        r.rx_byte = rx_last;
        r.rx_valid = rxv;
        r.ack_failed = fail;
        r.done = fin;
        return r;
    endfunction

    function automatic item_t make_item(input logic [2:0] f, input logic [7:0] tx,
                                        input logic ack, input logic sdi);
        item_t it;
        it.func = f;
        it.tx_byte = tx;
        it.send_ack = ack;
        it.sda_in = sdi;
        return it;
    endfunction

    // Ack quickly half the time, sometimes exactly at the poll limit, sometimes never
    function automatic int pick_ack_delay();
        int k;
        k = $urandom_range(9);
        if (k < 5) return $urandom_range(0, 2);
        if (k < 7) return int'(timing.poll_limit);
        return int'(timing.poll_limit) + 1;
    endfunction

    // Present one beat, hold it until accepted, then record its expected result
    task automatic send_item(input item_t it);
        res_t r;
        if (stall_en && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= it.func;
        s_tx_byte <= it.tx_byte;
        s_send_ack <= it.send_ack;
        s_sda_in <= it.sda_in;
        do @(posedge aclk); while (!s_ready);
        r = bus_step(it);
        bus_results_due.push_back(r);
        n_items++;
        if (r.rx_valid) n_bytes_read++;
        if (r.ack_failed) n_ack_fail++;
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (bus_results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_HOLD:       timing.hold = val[7:0];
            CFG_BIT_PHASE:  timing.bit_phase = val[7:0];
            CFG_SETTLE:     timing.settle = val[7:0];
            CFG_POLL_LIMIT: timing.poll_limit = val;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_timing(input logic [CFG_DATA_W-1:0] hold, bit_ph, settle, limit);
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_BIT_PHASE, bit_ph);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_POLL_LIMIT, limit);
        n_settings++;
    endtask

    // Tick the running command until it reaches halt_at or finishes.
    // Read bits come from rd_data; the slave acks after ack_after polls.
    task automatic clock_through(input phase_t halt_at, input int ack_after,
                                 input logic [7:0] rd_data, input int noise_pct);
        item_t it;
        while (ph != PH_IDLE && ph != halt_at) begin
            it.func = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7)) : FUNC_TICK;
            it.tx_byte = 8'($urandom);
            it.send_ack = 1'($urandom);
            it.sda_in = 1'($urandom);
            if (ph == PH_RD_HIGH)
                it.sda_in = rd_data[7 - nbits[2:0]];
            else if (ph == PH_ACK_POLL)
                it.sda_in = (int'(polls) < ack_after);
            send_item(it);
        end
    endtask

    task automatic run_cmd(input logic [2:0] f, input logic [7:0] tx, input logic ack,
                           input int ack_after, input logic [7:0] rd_data, input int noise_pct);
        send_item(make_item(f, tx, ack, 1'($urandom)));
        clock_through(PH_IDLE, ack_after, rd_data, noise_pct);
    endtask

    // Idle beats right after reset, including the unused func codes
    task automatic test_idle_items();
        send_item(make_item(FUNC_TICK, 8'h00, 1'b0, 1'b0));
        send_item(make_item(3'd5, 8'hFF, 1'b1, 1'b1));
        send_item(make_item(3'd6, 8'h0F, 1'b0, 1'b1));
        send_item(make_item(3'd7, 8'hF0, 1'b1, 1'b0));
    endtask

    // One full transaction on the power-up timing values
    task automatic test_reset_timing();
        run_cmd(FUNC_START, 8'h00, 1'b0, 0, 8'h00, 20);
        run_cmd(FUNC_WRITE, 8'hA5, 1'b0, 2, 8'h00, 20);
        run_cmd(FUNC_READ, 8'h00, 1'b1, 0, 8'h5A, 20);
        run_cmd(FUNC_STOP, 8'h00, 1'b0, 0, 8'h00, 20);
    endtask

    // All lengths zero (act as one), poll limit zero, byte extremes, busy commands
    task automatic test_zero_lengths();
        wait_drained();
        program_timing(10'd0, 10'd0, 10'd0, 10'd0);
        run_cmd(FUNC_START, 8'h00, 1'b0, 0, 8'h00, 50);
        run_cmd(FUNC_WRITE, 8'hFF, 1'b0, 1, 8'h00, 50);
        run_cmd(FUNC_WRITE, 8'h00, 1'b1, 0, 8'h00, 50);
        run_cmd(FUNC_READ, 8'hFF, 1'b1, 0, 8'hFF, 50);
        run_cmd(FUNC_READ, 8'h00, 1'b0, 0, 8'h00, 50);
        run_cmd(FUNC_STOP, 8'hFF, 1'b1, 0, 8'h00, 50);
    endtask

    // Largest lengths, shortened by register writes in the middle of commands
    task automatic test_slow_extremes();
        stall_en = 1'b0;
        wait_drained();
        program_timing(10'h3FF, 10'd255, 10'd255, 10'd1023);

        send_item(make_item(FUNC_START, 8'h00, 1'b0, 1'b1));
        clock_through(PH_ST_B, 0, 8'h00, 10);
        wait_drained();
        write_reg(CFG_HOLD, 10'd1);
        clock_through(PH_IDLE, 0, 8'h00, 10);

        send_item(make_item(FUNC_READ, 8'h00, 1'b1, 1'b0));
        clock_through(PH_RD_HIGH, 0, 8'hC3, 10);
        wait_drained();
        write_reg(CFG_BIT_PHASE, 10'd1);
        clock_through(PH_RD_LOW, 0, 8'hC3, 10);
        wait_drained();
        write_reg(CFG_SETTLE, 10'd1);
        clock_through(PH_IDLE, 0, 8'hC3, 10);

        // poll under the largest limit, then lower it below the count to give up
        send_item(make_item(FUNC_WRITE, 8'h96, 1'b0, 1'b1));
        clock_through(PH_ACK_POLL, 0, 8'h00, 10);
        repeat (20) send_item(make_item(FUNC_TICK, 8'h00, 1'b0, 1'b1));
        wait_drained();
        write_reg(CFG_POLL_LIMIT, 10'd5);
        clock_through(PH_IDLE, 1024, 8'h00, 10);
        stall_en = 1'b1;
    endtask

    // Transactions with random content over several small timing settings
    task automatic test_random_traffic(input int budget);
        int goal, n;
        for (int s = 0; s < 6; s++) begin
            wait_drained();
            program_timing({2'($urandom), 8'($urandom_range(0, 3))},
                           {2'($urandom), 8'($urandom_range(0, 3))},
                           {2'($urandom), 8'($urandom_range(0, 3))},
                           10'($urandom_range(0, 6)));
            stall_en = (s != 2);
            goal = n_items + budget / 6;
            while (n_items < goal) begin
                if ($urandom_range(99) < 15) begin
                    // stray command or idle beat outside a transaction
                    run_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom),
                            pick_ack_delay(), 8'($urandom), 15);
                end else begin
                    run_cmd(FUNC_START, 8'($urandom), 1'($urandom), 0, 8'h00, 15);
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        run_cmd($urandom_range(1) ? FUNC_WRITE : FUNC_READ, 8'($urandom),
                                1'($urandom), pick_ack_delay(), 8'($urandom), 15);
                    end
                    run_cmd(FUNC_STOP, 8'($urandom), 1'($urandom), 0, 8'h00, 15);
                end
            end
        end
        stall_en = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            if (n_errors < SHOWN_ERRORS)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            else if (n_errors == SHOWN_ERRORS)
                $display("%0t: further mismatches not shown", $time);
            n_errors++;
        end
    endtask

    // Random backpressure on the result side
    always @(posedge aclk) begin
        m_ready <= stall_en ? ($urandom_range(99) >= 33) : 1'b1;
    end

    // Compare each result beat against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (bus_results_due.size() == 0) begin
                $display("%0t: result beat arrived with nothing expected", $time);
                n_errors++;
            end else begin
                due = bus_results_due.pop_front();
                n_checked++;
                check_field("scl_level", 8'(due.scl_level), 8'(m_scl_level));
                check_field("sda_level", 8'(due.sda_level), 8'(m_sda_level));
                check_field("sda_drive", 8'(due.sda_drive), 8'(m_sda_drive));
                check_field("busy_res", 8'(due.busy), 8'(m_busy_res));
                check_field("rx_byte", due.rx_byte, m_rx_byte);
                check_field("rx_valid", 8'(due.rx_valid), 8'(m_rx_valid));
                check_field("ack_failed", 8'(due.ack_failed), 8'(m_ack_failed));
                check_field("done_res", 8'(due.done), 8'(m_done_res));
            end
        end
    end

    // Stop a hung run: no handshake or register write for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, bus_results_due.size());
            $display("** i2c_bit_level_master_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        timing.hold = HOLD_RST;
        timing.bit_phase = BIT_PHASE_RST;
        timing.settle = SETTLE_RST;
        timing.poll_limit = POLL_LIMIT_RST;
        ph = PH_IDLE;
        cmd = FUNC_TICK;
        tcnt = 8'd0;
        nbits = 4'd0;
        sh = 8'h00;
        polls = 10'd0;
        ack_sel = 1'b0;
        scl = 1'b1;
        sda = 1'b1;
        oe = 1'b1;
        rx_last = 8'h00;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_items();
        test_reset_timing();
        test_zero_lengths();
        test_slow_extremes();
        test_random_traffic(360);
        wait_drained();

        $display("Sent %0d beats over %0d register settings, checked %0d results",
                 n_items, n_settings + 1, n_checked);
        $display("Read %0d bytes, saw %0d writes end without acknowledge, %0d mismatches",
                 n_bytes_read, n_ack_fail, n_errors);
        if (n_errors == 0)
            $display("** i2c_bit_level_master_top: PASSED **");
        else
            $display("** i2c_bit_level_master_top: FAILED **");
        $finish;
    end

endmodule
